@@ rtl/ffha_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

  localparam int StatusW = 3;
  localparam int SizeW   = 14;
  localparam int FaddrW  = 14;
  localparam int DaddrW  = 13;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_NOFIT   = 3'd1;
  localparam logic [StatusW-1:0] ST_ZERO    = 3'd2;
  localparam logic [StatusW-1:0] ST_OUTSIDE = 3'd3;
  localparam logic [StatusW-1:0] ST_NULL    = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_A_RD   = 14'b00000000000100,
    S_A_CHK  = 14'b00000000001000,
    S_A_WCUR = 14'b00000000010000,
    S_L_RD   = 14'b00000000100000,
    S_L_WR   = 14'b00000001000000,
    S_F_RD   = 14'b00000010000000,
    S_F_CHK  = 14'b00000100000000,
    S_F_NCHK = 14'b00001000000000,
    S_F_WB   = 14'b00010000000000,
    S_F_PCHK = 14'b00100000000000,
    S_F_BINV = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

endpackage

@@ rtl/first_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
// First-fit heap allocator with coalescing over a header table in block RAM.
// Depends on ffha_pkg.
//
//  channel | dir | handshake        | payload
//  s_*     | in  | s_tvalid/tready  | tuser: req_type; tdata: req_size, free_addr
//  m_*     | out | m_tvalid/tready  | tdata: status, data_addr
//
// After reset a clearing pass writes every header entry with s_tready low.
// Alloc reads and checks each block header in turn; free checks the block's
// neighbours and merges free ones. All steps share one table read port and one
// write port. One request is in flight; the result register lets the next
// request be taken while the last result waits on m_tready.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int POOL_BYTES   = 8192,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [13:0] req_size, [27:14] free_addr, rest zero
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [2:0] status, [15:3] data_addr
);

  localparam int AW = $clog2(POOL_BYTES);
  localparam int CW = ((AW > 15) ? AW : 15) + 2;
  localparam logic [CW-1:0] HB = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] PB = CW'(POOL_BYTES);

  typedef struct packed {
    logic          valid;
    logic          used;
    logic [AW-1:0] size;
    logic [AW-1:0] prev;
  } entry_t;

  entry_t mem [POOL_BYTES];
  entry_t rdata, wdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;

  state_t state;
  logic [AW-1:0]      clr;
  logic [CW-1:0]      rsize, cur, csize, bsize, link;
  logic [AW-1:0]      b, eprev, lprev;
  logic               split, lret;
  logic [StatusW-1:0] res_st;
  logic [DaddrW-1:0]  res_addr;

  logic [SizeW-1:0]  req_size;
  logic [FaddrW-1:0] free_addr;
  logic [CW-1:0]     rsize_c, fa, a_end, f_end, n_end, psz;

  assign req_size  = s_tdata[13:0];
  assign free_addr = s_tdata[27:14];
  assign rsize_c   = (CW'(req_size) + CW'(3)) & ~CW'(3);
  assign fa        = CW'(free_addr);
  assign a_end     = cur + HB + CW'(rdata.size);
  assign f_end     = CW'(b) + HB + CW'(rdata.size);
  assign n_end     = link + HB + CW'(rdata.size);
  assign psz       = CW'(rdata.size) + HB + bsize;
  assign s_tready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // table port control
  always_comb begin
    raddr = '0;
    waddr = '0;
    wdata = '0;
    we    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        if (clr == '0) begin
          wdata = '{valid: 1'b1, used: 1'b0, size: AW'(PB - HB), prev: '0};
        end
      end
      S_A_RD:  raddr = cur[AW-1:0];
      S_A_CHK: begin
        // split: new free block after the taken part
        if (rdata.valid && !rdata.used && CW'(rdata.size) >= rsize &&
            CW'(rdata.size) >= rsize + (HB << 1)) begin
          we    = 1'b1;
          waddr = AW'(cur + HB + rsize);
          wdata = '{valid: 1'b1, used: 1'b0,
                    size: AW'(CW'(rdata.size) - rsize - HB), prev: cur[AW-1:0]};
        end
      end
      S_A_WCUR: begin
        we    = 1'b1;
        waddr = cur[AW-1:0];
        wdata = '{valid: 1'b1, used: 1'b1, size: AW'(csize), prev: eprev};
      end
      S_L_RD:  raddr = link[AW-1:0];
      S_L_WR: begin
        we    = 1'b1;
        waddr = link[AW-1:0];
        wdata = '{valid: rdata.valid, used: rdata.used, size: rdata.size, prev: lprev};
      end
      S_F_RD:  raddr = b;
      S_F_CHK: raddr = f_end[AW-1:0];
      S_F_NCHK: begin
        if (!rdata.used) begin
          we    = 1'b1;
          waddr = link[AW-1:0];
          wdata = '{valid: 1'b0, used: rdata.used, size: rdata.size, prev: rdata.prev};
        end
      end
      S_F_WB: begin
        we    = 1'b1;
        waddr = b;
        wdata = '{valid: 1'b1, used: 1'b0, size: AW'(bsize), prev: eprev};
        raddr = eprev;
      end
      S_F_PCHK: begin
        if (rdata.valid && !rdata.used) begin
          we    = 1'b1;
          waddr = eprev;
          wdata = '{valid: 1'b1, used: 1'b0, size: AW'(psz), prev: rdata.prev};
        end
      end
      S_F_BINV: begin
        we    = 1'b1;
        waddr = b;
        wdata = '{valid: 1'b0, used: 1'b0, size: AW'(bsize), prev: eprev};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(POOL_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            res_addr <= '0;
            res_st   <= ST_OK;
            if (s_tuser == REQ_ALLOC) begin
              if (rsize_c == '0) begin
                res_st <= ST_ZERO;
                state  <= S_DONE;
              end else begin
                rsize <= rsize_c;
                cur   <= '0;
                state <= S_A_RD;
              end
            end else begin
              priority if (fa == '0) begin
                res_st <= ST_NULL;
                state  <= S_DONE;
              end else if (fa < HB || fa - HB >= PB) begin
                res_st <= ST_OUTSIDE;
                state  <= S_DONE;
              end else begin
                b     <= AW'(fa - HB);
                state <= S_F_RD;
              end
            end
          end
        end
        S_A_RD: begin
          if (cur >= PB) begin
            res_st <= ST_NOFIT;
            state  <= S_DONE;
          end else begin
            state <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          priority if (!rdata.valid) begin
            res_st <= ST_NOFIT;
            state  <= S_DONE;
          end else if (!rdata.used && CW'(rdata.size) >= rsize) begin
            eprev <= rdata.prev;
            if (CW'(rdata.size) >= rsize + (HB << 1)) begin
              split <= 1'b1;
              csize <= rsize;
              link  <= a_end;
            end else begin
              split <= 1'b0;
              csize <= CW'(rdata.size);
            end
            state <= S_A_WCUR;
          end else begin
            cur   <= a_end;
            state <= S_A_RD;
          end
        end
        S_A_WCUR: begin
          res_addr <= DaddrW'(cur + HB);
          if (split) begin
            lprev <= AW'(cur + HB + rsize);
            lret  <= 1'b0;
            state <= S_L_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_L_RD: begin
          if (link < PB) begin
            state <= S_L_WR;
          end else begin
            state <= lret ? S_F_WB : S_DONE;
          end
        end
        S_L_WR:  state <= lret ? S_F_WB : S_DONE;
        S_F_RD:  state <= S_F_CHK;
        S_F_CHK: begin
          if (!rdata.valid) begin
            res_st <= ST_OUTSIDE;
            state  <= S_DONE;
          end else begin
            eprev <= rdata.prev;
            bsize <= CW'(rdata.size);
            link  <= f_end;
            state <= (f_end < PB) ? S_F_NCHK : S_F_WB;
          end
        end
        S_F_NCHK: begin
          if (!rdata.used) begin
            // absorb successor, then fix the back link behind it
            bsize <= bsize + HB + CW'(rdata.size);
            link  <= n_end;
            lprev <= b;
            lret  <= 1'b1;
            state <= S_L_RD;
          end else begin
            state <= S_F_WB;
          end
        end
        S_F_WB:  state <= (b != '0) ? S_F_PCHK : S_DONE;
        S_F_PCHK: begin
          if (rdata.valid && !rdata.used) begin
            link  <= CW'(eprev) + HB + psz;
            lprev <= eprev;
            lret  <= 1'b0;
            state <= S_F_BINV;
          end else begin
            state <= S_DONE;
          end
        end
        S_F_BINV: state <= S_L_RD;
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_addr, res_st};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_addr_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15:3] != '0 |-> m_tdata[2:0] == ST_OK)
    else $error("nonzero address on failed request");
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !s_tready && !m_tvalid)
    else $error("activity during clearing pass");
  a_done_load: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!m_tvalid || m_tready) |=> m_tvalid && state == S_IDLE)
    else $error("result not loaded");
`endif

endmodule
